/* hw/rtl/dlt_storage_message_indexer_top_defines.svh */
// assertion macros for the storage message indexer
// no dependencies; clock i_clk and reset i_rst_n are taken from the using module
`ifndef DLT_STORAGE_MESSAGE_INDEXER_TOP_DEFINES_SVH
`define DLT_STORAGE_MESSAGE_INDEXER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define DSMI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define DSMI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define DSMI_ASSERT(lbl, prop, msg)
`define DSMI_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hw/rtl/dsmi_pkg.sv */
// shared types and constants of the storage message indexer
// no dependencies
package dsmi_pkg;

    localparam int POS_W   = 40;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int HC_W    = 9;
    localparam int LFO_W   = 3;

    localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPLAY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINAL  = 2'd2;

    localparam logic [BYTE_W-1:0] CH_D      = 8'h44;
    localparam logic [BYTE_W-1:0] CH_L      = 8'h4C;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h54;
    localparam logic [BYTE_W-1:0] MARK_V1   = 8'h01;
    localparam logic [BYTE_W-1:0] MARK_V2   = 8'h02;
    localparam logic [BYTE_W-1:0] VER_MASK  = 8'hE0;
    localparam logic [2:0]        VER2      = 3'd2;

    localparam logic [HC_W-1:0]  SL_V1     = 9'd16;
    localparam logic [HC_W-1:0]  SL_V2     = 9'd13;
    localparam logic [HC_W-1:0]  HC_START  = 9'd3;
    localparam logic [LFO_W-1:0] LFO_V2    = 3'd5;
    localparam logic [LFO_W-1:0] LFO_DEF   = 3'd2;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
    } t_result;

endpackage

/* hw/rtl/dsmi_in_stage.sv */
// input register of the storage message indexer
// depends on dsmi_pkg
module dsmi_in_stage #(
    parameter int OFFSET_WIDTH = 40
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [dsmi_pkg::BYTE_W-1:0]  i_byte_value,
    input  logic [dsmi_pkg::POS_W-1:0]   i_byte_offset,
    input  logic                         i_out_ready,
    output logic                         o_stall,
    output logic                         o_fire,
    output logic [dsmi_pkg::BYTE_W-1:0]  o_byte,
    output logic [OFFSET_WIDTH-1:0]      o_offset
);
    import dsmi_pkg::*;

    localparam int WIDE_W = (OFFSET_WIDTH > POS_W) ? OFFSET_WIDTH : POS_W;

    logic                    r_valid;
    logic [BYTE_W-1:0]       r_byte;
    logic [OFFSET_WIDTH-1:0] r_offset;
    logic [WIDE_W-1:0]       off_wide;
    logic                    take;

    assign off_wide = WIDE_W'(i_byte_offset);
    assign o_fire   = r_valid && i_out_ready;
    assign o_stall  = r_valid && !i_out_ready;
    assign take     = i_valid && !o_stall;
    assign o_byte   = r_byte;
    assign o_offset = r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (o_fire) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte   <= i_byte_value;
            r_offset <= off_wide[OFFSET_WIDTH-1:0];
        end
    end

endmodule

/* hw/rtl/dsmi_scan.sv */
// marker search and storage header walk, one byte per cycle while i_fire is high
// depends on dsmi_pkg and the assertion macro header
`include "dlt_storage_message_indexer_top_defines.svh"

module dsmi_scan #(
    parameter int OFFSET_WIDTH = 40
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dsmi_pkg::POS_W-1:0]   i_cfg_wdata,
    input  logic                         i_fire,
    input  logic [dsmi_pkg::BYTE_W-1:0]  i_byte,
    input  logic [OFFSET_WIDTH-1:0]      i_offset,
    output dsmi_pkg::t_result            o_res
);
    import dsmi_pkg::*;

    localparam int WIDE_W = (OFFSET_WIDTH > POS_W) ? OFFSET_WIDTH : POS_W;

    typedef enum logic [1:0] {MP_NONE, MP_D, MP_DL, MP_DLT} t_marker;

    t_marker                 r_mp, n_mp;
    logic [HC_W-1:0]         r_hc, n_hc;
    logic [HC_W-1:0]         r_sl, n_sl;
    logic [LFO_W-1:0]        r_lfo, n_lfo;
    logic [BYTE_W-1:0]       r_len_hi, n_len_hi;
    logic [OFFSET_WIDTH-1:0] r_cur_start, n_cur_start;
    logic [OFFSET_WIDTH-1:0] r_exp_next, n_exp_next;
    logic [OFFSET_WIDTH-1:0] r_exp_off, n_exp_off;
    logic                    r_finished, n_finished;
    logic [OFFSET_WIDTH-1:0] r_fsize;

    logic [HC_W-1:0]         hc_inc;
    logic [HC_W:0]           sl_lfo;
    logic [15:0]             len16;
    logic [OFFSET_WIDTH-1:0] end_sum;
    logic [OFFSET_WIDTH-1:0] start;
    logic [OFFSET_WIDTH-1:0] resume;
    logic [WIDE_W-1:0]       cs_wide;
    logic [WIDE_W-1:0]       resume_wide;
    logic [WIDE_W-1:0]       fs_wide;
    logic [2:0]              ver;
    logic                    is_marker;

    assign hc_inc      = r_hc + 9'd1;
    assign sl_lfo      = {1'b0, r_sl} + {{(HC_W-LFO_W+1){1'b0}}, r_lfo};
    assign len16       = {r_len_hi, i_byte} + {7'd0, r_sl};
    assign end_sum     = r_cur_start + OFFSET_WIDTH'(len16);
    assign start       = i_offset - OFFSET_WIDTH'(3);
    assign resume      = r_cur_start + OFFSET_WIDTH'(4);
    assign cs_wide     = WIDE_W'(r_cur_start);
    assign resume_wide = WIDE_W'(resume);
    assign fs_wide     = WIDE_W'(i_cfg_wdata);
    assign ver         = 3'((i_byte & VER_MASK) >> 5);
    assign is_marker   = (r_mp == MP_DLT) && (i_byte == MARK_V1 || i_byte == MARK_V2);

    always_comb begin
        n_mp        = r_mp;
        n_hc        = r_hc;
        n_sl        = r_sl;
        n_lfo       = r_lfo;
        n_len_hi    = r_len_hi;
        n_cur_start = r_cur_start;
        n_exp_next  = r_exp_next;
        n_exp_off   = r_exp_off;
        n_finished  = r_finished;
        o_res       = '0;

        if (i_fire && !r_finished && i_offset == r_exp_off) begin
            n_exp_off = r_exp_off + OFFSET_WIDTH'(1);
            if (r_hc != '0) begin
                n_hc = hc_inc;
                if (r_sl == SL_V2 && hc_inc == SL_V2) begin
                    // ecu-id length byte extends the storage header
                    n_sl = r_sl + {1'b0, i_byte} + 9'd1;
                end else if (hc_inc == r_sl) begin
                    n_lfo = (ver == VER2) ? LFO_V2 : LFO_DEF;
                end else if ({1'b0, hc_inc} == sl_lfo) begin
                    n_len_hi = i_byte;
                end else if ({1'b0, hc_inc} == sl_lfo + 10'd1) begin
                    n_hc       = '0;
                    n_exp_next = end_sum;
                    if (end_sum == r_fsize) begin
                        o_res.valid    = 1'b1;
                        o_res.kind     = KIND_FINAL;
                        o_res.position = cs_wide[POS_W-1:0];
                        n_finished     = 1'b1;
                    end
                end
            end else if (i_byte == CH_D) begin
                n_mp = MP_D;
            end else if (r_mp == MP_D && i_byte == CH_L) begin
                n_mp = MP_DL;
            end else if (r_mp == MP_DL && i_byte == CH_T) begin
                n_mp = MP_DLT;
            end else if (is_marker) begin
                n_mp = MP_NONE;
                if (r_exp_next == '0 || r_exp_next == start) begin
                    if (r_exp_next != '0) begin
                        o_res.valid    = 1'b1;
                        o_res.kind     = KIND_START;
                        o_res.position = cs_wide[POS_W-1:0];
                    end
                    n_cur_start = start;
                    n_hc        = HC_START;
                    n_sl        = (i_byte == MARK_V1) ? SL_V1 : SL_V2;
                end else if (r_exp_next < start) begin
                    // marker past the expected end: rescan from the current message start plus four
                    o_res.valid    = 1'b1;
                    o_res.kind     = KIND_REPLAY;
                    o_res.position = resume_wide[POS_W-1:0];
                    n_exp_off      = resume;
                    n_exp_next     = '0;
                end
            end else begin
                n_mp = MP_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mp        <= MP_NONE;
            r_hc        <= '0;
            r_sl        <= '0;
            r_lfo       <= LFO_DEF;
            r_len_hi    <= '0;
            r_cur_start <= '0;
            r_exp_next  <= '0;
            r_exp_off   <= '0;
            r_finished  <= 1'b0;
            r_fsize     <= '0;
        end else begin
            r_mp        <= n_mp;
            r_hc        <= n_hc;
            r_sl        <= n_sl;
            r_lfo       <= n_lfo;
            r_len_hi    <= n_len_hi;
            r_cur_start <= n_cur_start;
            r_exp_next  <= n_exp_next;
            r_exp_off   <= n_exp_off;
            r_finished  <= n_finished;
            if (i_cfg_we) begin
                r_fsize <= fs_wide[OFFSET_WIDTH-1:0];
            end
        end
    end

    `DSMI_ASSERT(a_finished_sticky, r_finished |=> r_finished, "finished flag cleared")
    `DSMI_ASSERT(a_header_no_marker, (r_hc != '0) |-> (r_mp == MP_NONE), "marker state in header")
    `DSMI_ASSERT(a_final_sets_done, (o_res.valid && o_res.kind == KIND_FINAL) |=> r_finished, "final without stop")
    `DSMI_ASSERT(a_quiet_when_done, r_finished |-> !o_res.valid, "result after final")

endmodule

/* hw/rtl/dsmi_out_stage.sv */
// result register of the storage message indexer
// depends on dsmi_pkg
module dsmi_out_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  dsmi_pkg::t_result            i_res,
    input  logic                         i_stall,
    output logic                         o_ready,
    output logic                         o_valid,
    output logic [dsmi_pkg::KIND_W-1:0]  o_record_kind,
    output logic [dsmi_pkg::POS_W-1:0]   o_position
);
    import dsmi_pkg::*;

    logic              r_valid;
    logic [KIND_W-1:0] r_kind;
    logic [POS_W-1:0]  r_position;

    assign o_ready       = !r_valid || !i_stall;
    assign o_valid       = r_valid;
    assign o_record_kind = r_kind;
    assign o_position    = r_position;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_fire && i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_fire && i_res.valid) begin
            r_kind     <= i_res.kind;
            r_position <= i_res.position;
        end
    end

endmodule

/* hw/rtl/dlt_storage_message_indexer_top.sv */
// top level of the storage log message indexer
// depends on dsmi_pkg, dsmi_in_stage, dsmi_scan, dsmi_out_stage and the macro header
//
// usage:
//   input channel: i_valid / o_stall with i_byte_value and i_byte_offset, one file
//   byte per transaction; bytes whose offset is not the next expected one are dropped
//   output channel: o_valid / i_stall with o_record_kind (0 start, 1 replay, 2 final)
//   and o_position; zero or one result per byte
//   config: i_cfg_we writes i_cfg_wdata into the file size register; use only while idle, not enforced
// timing:
//   one byte per cycle while no stall holds the flow; a byte is held in the input register,
//   and its result is registered into the output register when the byte fires
//   the whole per-byte decision is combinational logic between the two registers
// reset:
//   synchronous i_rst_n clears the scan state, the file size and both stages
// stall:
//   when the output register is full and i_stall is high, a byte in the input register
//   holds and o_stall rises; no result is dropped
//   after a replay request the feeder must resend bytes from the given position
//   after a final result all further bytes are dropped until reset
`include "dlt_storage_message_indexer_top_defines.svh"

module dlt_storage_message_indexer_top #(
    parameter int OFFSET_WIDTH = 40
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dsmi_pkg::POS_W-1:0]   i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [dsmi_pkg::BYTE_W-1:0]  i_byte_value,
    input  logic [dsmi_pkg::POS_W-1:0]   i_byte_offset,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [dsmi_pkg::KIND_W-1:0]  o_record_kind,
    output logic [dsmi_pkg::POS_W-1:0]   o_position
);
    import dsmi_pkg::*;

    logic                    out_ready;
    logic                    fire;
    logic [BYTE_W-1:0]       st_byte;
    logic [OFFSET_WIDTH-1:0] st_offset;
    t_result                 res;

    dsmi_in_stage #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_byte_value (i_byte_value),
        .i_byte_offset(i_byte_offset),
        .i_out_ready  (out_ready),
        .o_stall      (o_stall),
        .o_fire       (fire),
        .o_byte       (st_byte),
        .o_offset     (st_offset)
    );

    dsmi_scan #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_fire     (fire),
        .i_byte     (st_byte),
        .i_offset   (st_offset),
        .o_res      (res)
    );

    dsmi_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_res        (res),
        .i_stall      (i_stall),
        .o_ready      (out_ready),
        .o_valid      (o_valid),
        .o_record_kind(o_record_kind),
        .o_position   (o_position)
    );

    `DSMI_ASSERT(a_result_from_fire, out_ready && !(fire && res.valid) |=> !o_valid, "stray result")
    `DSMI_ASSERT(a_stall_needs_full, o_stall |-> (o_valid && i_stall), "stall while output free")
    `DSMI_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule
